// File: design/btm_pkg.sv
// ----------------------------------------------------------------------------
// btm_pkg
// Shared types, codes and hash helpers for the bloom token membership test.
// ----------------------------------------------------------------------------
package btm_pkg;

  // Hash constants
  localparam logic [31:0] DJB_INIT  = 32'd5381;
  localparam logic [31:0] FNV_INIT  = 32'd2166136261;
  localparam logic [31:0] SDBM_INIT = 32'd0;

  // Masked index width: index_bits is four bits wide, so at most 15 index bits
  localparam int HIDX_W = 15;

  // Item action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [0:0] CFG_TOKENIZE   = 1'b0;
  localparam logic [0:0] CFG_INDEX_BITS = 1'b1;

  typedef struct packed {
    logic       action;
    logic [9:0] load_address;
    logic [7:0] load_data;
    logic [7:0] query_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic possibly_present;
    logic whole_query_used;
  } out_item_t;

  typedef struct packed {
    logic       tokenize_mode;
    logic [3:0] index_bits;
  } cfg_t;

  typedef enum logic [1:0] {
    JOB_LOAD,
    JOB_TOKEN,
    JOB_END
  } job_kind_t;

  // One word of work for the back end
  typedef struct packed {
    job_kind_t               kind;
    logic                    whole;
    logic                    use_test;
    logic [2:0][HIDX_W-1:0]  idx;
    logic [9:0]              load_address;
    logic [7:0]              load_data;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RD0,
    BK_RD1,
    BK_RD2,
    BK_CHK,
    BK_FIN
  } bk_state_t;

  function automatic logic is_separator(input logic [7:0] c);
    return (c == 8'd32) || (c == 8'd34) || (c == 8'd58) || (c == 8'd10) ||
           (c == 8'd13) || (c == 8'd9)  || (c == 8'd44) || (c == 8'd123) ||
           (c == 8'd125) || (c == 8'd91) || (c == 8'd93);
  endfunction

  // h * 33 + c
  function automatic logic [31:0] upd_djb(input logic [31:0] h, input logic [7:0] c);
    return (h << 5) + h + {24'd0, c};
  endfunction

  // (h ^ c) * 16777619, prime taken apart as 2^24 + 2^8 + 2^7 + 2^4 + 2 + 1
  function automatic logic [31:0] upd_fnv(input logic [31:0] h, input logic [7:0] c);
    logic [31:0] x;
    x = h ^ {24'd0, c};
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

  // c + (h << 6) + (h << 16) - h
  function automatic logic [31:0] upd_sdbm(input logic [31:0] h, input logic [7:0] c);
    return {24'd0, c} + (h << 6) + (h << 16) - h;
  endfunction

  // Keep the low index_bits bits of a hash
  function automatic logic [HIDX_W-1:0] mask_index(input logic [31:0] h,
                                                   input logic [3:0] bits);
    logic [15:0] m;
    m = (16'd1 << bits) - 16'd1;
    return h[HIDX_W-1:0] & m[HIDX_W-1:0];
  endfunction

endpackage

// File: design/bloom_token_membership_test.sv
// ----------------------------------------------------------------------------
// bloom_token_membership_test
// Bloom filter membership test with djb2, FNV-1a and sdbm hashes over tokens.
// ----------------------------------------------------------------------------
// Load the filter with action 0 words (one byte each), then stream query bytes
// with action 1 and flag the final byte with last; one result word per query
// comes out. The front end takes one word per cycle while the job queue has
// room. The back end owns the filter RAM's single read port: a load is written
// as it is popped, a token end steps through pop, three reads, combine and
// settle, as does a query end that tests bits, while a query end that only
// reports the running verdict goes straight from pop to settle and waits there
// until the result slot is free. When short tokens or queries fill the job
// queue faster than the back end drains it, in_full holds off new words.
// Filter bytes never written read back as unknown; no clearing pass is run.
// ----------------------------------------------------------------------------
module bloom_token_membership_test #(
  parameter int BLOOM_BITS  = 8192,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  btm_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output btm_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  localparam int ADDR_W      = $clog2(BLOOM_BITS) - 3;
  localparam int STORE_DEPTH = (BLOOM_BITS + 7) / 8;

  btm_pkg::cfg_t       cfg_r, cfg_nxt;
  btm_pkg::job_t       job;
  btm_pkg::job_t       q_head;
  logic                job_valid;
  logic                accept;
  logic                q_push;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [7:0]          ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [7:0]          ram_rdata;

  // Configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        btm_pkg::CFG_TOKENIZE:   cfg_nxt.tokenize_mode = cfg_data[0];
        btm_pkg::CFG_INDEX_BITS: cfg_nxt.index_bits    = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tokenize_mode <= 1'b1;
      cfg_r.index_bits    <= 4'd13;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept && job_valid;

  btm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .item      (in_item),
    .accept    (accept),
    .job       (job),
    .job_valid (job_valid)
  );

  btm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (job),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty)
  );

  btm_back #(
    .BLOOM_BITS (BLOOM_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

  btm_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job queue popped while empty");

  // Loads and query ends always leave a job behind
  a_job_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.action == btm_pkg::ACT_LOAD || in_item.last)) |=> !q_empty)
    else $error("load or query end accepted without a queued job");

  // Filter writes and bit lookups never share a cycle
  a_ram_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("filter RAM written and read in the same cycle");

endmodule

// File: design/btm_ram.sv
// ----------------------------------------------------------------------------
// btm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module btm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/btm_queue.sv
// ----------------------------------------------------------------------------
// btm_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module btm_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  btm_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output btm_pkg::job_t head,
  output logic          empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  btm_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: design/btm_front.sv
// ----------------------------------------------------------------------------
// btm_front
// Front end: runs the token and whole-query hashes one byte per cycle while
// words are accepted, and turns loads, token ends and query ends into back end jobs.
// ----------------------------------------------------------------------------
module btm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  btm_pkg::cfg_t     cfg,
  input  btm_pkg::in_item_t item,
  input  logic              accept,
  output btm_pkg::job_t     job,
  output logic              job_valid
);

  logic [31:0] tok_djb_r, tok_djb_nxt;
  logic [31:0] tok_fnv_r, tok_fnv_nxt;
  logic [31:0] tok_sdbm_r, tok_sdbm_nxt;
  logic [31:0] all_djb_r, all_djb_nxt;
  logic [31:0] all_fnv_r, all_fnv_nxt;
  logic [31:0] all_sdbm_r, all_sdbm_nxt;
  logic        inside_r, inside_nxt;
  logic        seen_r, seen_nxt;

  logic [31:0] w_djb, w_fnv, w_sdbm;
  logic [31:0] t_djb, t_fnv, t_sdbm;
  logic [31:0] c_djb, c_fnv, c_sdbm;
  logic        is_sep;
  logic        close_now;
  logic        seen_after;

  // Hash updates for the current byte
  always_comb begin
    w_djb      = btm_pkg::upd_djb(all_djb_r, item.query_byte);
    w_fnv      = btm_pkg::upd_fnv(all_fnv_r, item.query_byte);
    w_sdbm     = btm_pkg::upd_sdbm(all_sdbm_r, item.query_byte);
    t_djb      = btm_pkg::upd_djb(tok_djb_r, item.query_byte);
    t_fnv      = btm_pkg::upd_fnv(tok_fnv_r, item.query_byte);
    t_sdbm     = btm_pkg::upd_sdbm(tok_sdbm_r, item.query_byte);
    is_sep     = btm_pkg::is_separator(item.query_byte);
    // on a final byte the open token closes, with or without this byte
    close_now  = is_sep ? inside_r : 1'b1;
    seen_after = seen_r | close_now;
    c_djb      = is_sep ? tok_djb_r  : t_djb;
    c_fnv      = is_sep ? tok_fnv_r  : t_fnv;
    c_sdbm     = is_sep ? tok_sdbm_r : t_sdbm;
  end

  // Classify the item into a job
  always_comb begin
    job              = '0;
    job_valid        = 1'b0;
    job.load_address = item.load_address;
    job.load_data    = item.load_data;
    if (item.action == btm_pkg::ACT_LOAD) begin
      job.kind  = btm_pkg::JOB_LOAD;
      job_valid = 1'b1;
    end else if (item.last) begin
      job.kind  = btm_pkg::JOB_END;
      job_valid = 1'b1;
      if (cfg.tokenize_mode && seen_after) begin
        job.whole    = 1'b0;
        job.use_test = close_now;
        job.idx[0]   = btm_pkg::mask_index(c_djb, cfg.index_bits);
        job.idx[1]   = btm_pkg::mask_index(c_fnv, cfg.index_bits);
        job.idx[2]   = btm_pkg::mask_index(c_sdbm, cfg.index_bits);
      end else begin
        job.whole    = 1'b1;
        job.use_test = 1'b1;
        job.idx[0]   = btm_pkg::mask_index(w_djb, cfg.index_bits);
        job.idx[1]   = btm_pkg::mask_index(w_fnv, cfg.index_bits);
        job.idx[2]   = btm_pkg::mask_index(w_sdbm, cfg.index_bits);
      end
    end else if (is_sep && inside_r) begin
      job.kind     = btm_pkg::JOB_TOKEN;
      job.use_test = 1'b1;
      job_valid    = 1'b1;
      job.idx[0]   = btm_pkg::mask_index(tok_djb_r, cfg.index_bits);
      job.idx[1]   = btm_pkg::mask_index(tok_fnv_r, cfg.index_bits);
      job.idx[2]   = btm_pkg::mask_index(tok_sdbm_r, cfg.index_bits);
    end
  end

  // Advance the query state
  always_comb begin
    tok_djb_nxt  = tok_djb_r;
    tok_fnv_nxt  = tok_fnv_r;
    tok_sdbm_nxt = tok_sdbm_r;
    all_djb_nxt  = all_djb_r;
    all_fnv_nxt  = all_fnv_r;
    all_sdbm_nxt = all_sdbm_r;
    inside_nxt   = inside_r;
    seen_nxt     = seen_r;
    if (accept && item.action == btm_pkg::ACT_QUERY) begin
      if (item.last) begin
        // query done: start afresh
        tok_djb_nxt  = btm_pkg::DJB_INIT;
        tok_fnv_nxt  = btm_pkg::FNV_INIT;
        tok_sdbm_nxt = btm_pkg::SDBM_INIT;
        all_djb_nxt  = btm_pkg::DJB_INIT;
        all_fnv_nxt  = btm_pkg::FNV_INIT;
        all_sdbm_nxt = btm_pkg::SDBM_INIT;
        inside_nxt   = 1'b0;
        seen_nxt     = 1'b0;
      end else begin
        all_djb_nxt  = w_djb;
        all_fnv_nxt  = w_fnv;
        all_sdbm_nxt = w_sdbm;
        if (is_sep) begin
          if (inside_r) begin
            tok_djb_nxt  = btm_pkg::DJB_INIT;
            tok_fnv_nxt  = btm_pkg::FNV_INIT;
            tok_sdbm_nxt = btm_pkg::SDBM_INIT;
            inside_nxt   = 1'b0;
            seen_nxt     = 1'b1;
          end
        end else begin
          tok_djb_nxt  = t_djb;
          tok_fnv_nxt  = t_fnv;
          tok_sdbm_nxt = t_sdbm;
          inside_nxt   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_djb_r  <= btm_pkg::DJB_INIT;
      tok_fnv_r  <= btm_pkg::FNV_INIT;
      tok_sdbm_r <= btm_pkg::SDBM_INIT;
      all_djb_r  <= btm_pkg::DJB_INIT;
      all_fnv_r  <= btm_pkg::FNV_INIT;
      all_sdbm_r <= btm_pkg::SDBM_INIT;
      inside_r   <= 1'b0;
      seen_r     <= 1'b0;
    end else begin
      tok_djb_r  <= tok_djb_nxt;
      tok_fnv_r  <= tok_fnv_nxt;
      tok_sdbm_r <= tok_sdbm_nxt;
      all_djb_r  <= all_djb_nxt;
      all_fnv_r  <= all_fnv_nxt;
      all_sdbm_r <= all_sdbm_nxt;
      inside_r   <= inside_nxt;
      seen_r     <= seen_nxt;
    end
  end

endmodule

// File: design/btm_back.sv
// ----------------------------------------------------------------------------
// btm_back
// Back end: writes bloom bytes, looks up the three bits of each tested token
// through the single RAM read port, keeps the running verdict and holds the
// result word until it is taken.
// ----------------------------------------------------------------------------
module btm_back #(
  parameter int BLOOM_BITS = 8192,
  localparam int ADDR_W = $clog2(BLOOM_BITS) - 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  btm_pkg::job_t      q_head,
  output logic               q_pop,
  output logic               ram_we,
  output logic [ADDR_W-1:0]  ram_waddr,
  output logic [7:0]         ram_wdata,
  output logic               ram_re,
  output logic [ADDR_W-1:0]  ram_raddr,
  input  logic [7:0]         ram_rdata,
  input  logic               out_pop,
  output logic               out_empty,
  output btm_pkg::out_item_t out_item
);

  localparam int IDX_W      = $clog2(BLOOM_BITS);
  localparam int LOAD_LIMIT = BLOOM_BITS / 8;

  // Number of conditional subtract steps that bring a masked index below
  // the filter size
  function automatic int calc_red_steps(input int bb);
    int s;
    s = 0;
    for (int k = 0; k < 16; k++) begin
      if ((bb << k) <= (1 << btm_pkg::HIDX_W) - 1) begin
        s = s + 1;
      end
    end
    return s;
  endfunction

  localparam int RED_STEPS = calc_red_steps(BLOOM_BITS);

  btm_pkg::bk_state_t       state_r, state_nxt;
  btm_pkg::job_kind_t       jkind_r, jkind_nxt;
  logic                     jwhole_r, jwhole_nxt;
  logic [2:0][ADDR_W-1:0]   jaddr_r, jaddr_nxt;
  logic [2:0][2:0]          jsel_r, jsel_nxt;
  logic                     hit_r, hit_nxt;
  logic                     passed_r, passed_nxt;
  logic                     out_valid_r, out_valid_nxt;
  btm_pkg::out_item_t       out_item_r, out_item_nxt;
  logic [2:0][IDX_W-1:0]    red;

  // Reduce each masked index modulo the filter size
  always_comb begin
    logic [15:0] v;
    for (int k = 0; k < 3; k++) begin
      v = {1'b0, q_head.idx[k]};
      for (int j = RED_STEPS - 1; j >= 0; j--) begin
        if (v >= 16'(BLOOM_BITS << j)) begin
          v = v - 16'(BLOOM_BITS << j);
        end
      end
      red[k] = v[IDX_W-1:0];
    end
  end

  // Sequence loads, bit lookups and the verdict
  always_comb begin
    state_nxt     = state_r;
    jkind_nxt     = jkind_r;
    jwhole_nxt    = jwhole_r;
    jaddr_nxt     = jaddr_r;
    jsel_nxt      = jsel_r;
    hit_nxt       = hit_r;
    passed_nxt    = passed_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = ADDR_W'(q_head.load_address);
    ram_wdata     = q_head.load_data;
    ram_re        = 1'b0;
    ram_raddr     = jaddr_r[0];
    case (state_r)
      btm_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_head.kind)
            btm_pkg::JOB_LOAD: begin
              // drop writes beyond the store
              ram_we = (32'(q_head.load_address) < LOAD_LIMIT);
            end
            btm_pkg::JOB_TOKEN, btm_pkg::JOB_END: begin
              jkind_nxt  = q_head.kind;
              jwhole_nxt = q_head.whole;
              hit_nxt    = 1'b1;
              for (int k = 0; k < 3; k++) begin
                jaddr_nxt[k] = red[k][IDX_W-1:3];
                jsel_nxt[k]  = red[k][2:0];
              end
              state_nxt = q_head.use_test ? btm_pkg::BK_RD0 : btm_pkg::BK_FIN;
            end
            default: begin
            end
          endcase
        end
      end
      btm_pkg::BK_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = jaddr_r[0];
        state_nxt = btm_pkg::BK_RD1;
      end
      btm_pkg::BK_RD1: begin
        ram_re    = 1'b1;
        ram_raddr = jaddr_r[1];
        hit_nxt   = hit_r & ram_rdata[jsel_r[0]];
        state_nxt = btm_pkg::BK_RD2;
      end
      btm_pkg::BK_RD2: begin
        ram_re    = 1'b1;
        ram_raddr = jaddr_r[2];
        hit_nxt   = hit_r & ram_rdata[jsel_r[1]];
        state_nxt = btm_pkg::BK_CHK;
      end
      btm_pkg::BK_CHK: begin
        hit_nxt   = hit_r & ram_rdata[jsel_r[2]];
        state_nxt = btm_pkg::BK_FIN;
      end
      btm_pkg::BK_FIN: begin
        if (jkind_r == btm_pkg::JOB_TOKEN) begin
          passed_nxt = passed_r & hit_r;
          state_nxt  = btm_pkg::BK_IDLE;
        end else if (!out_valid_r || out_pop) begin
          // hand over the verdict and open a fresh query
          out_valid_nxt                 = 1'b1;
          out_item_nxt.whole_query_used = jwhole_r;
          out_item_nxt.possibly_present = jwhole_r ? hit_r : (passed_r & hit_r);
          passed_nxt                    = 1'b1;
          state_nxt                     = btm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = btm_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btm_pkg::BK_IDLE;
      passed_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      passed_r    <= passed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold job details and the result word
  always_ff @(posedge clk) begin
    jkind_r    <= jkind_nxt;
    jwhole_r   <= jwhole_nxt;
    jaddr_r    <= jaddr_nxt;
    jsel_r     <= jsel_nxt;
    hit_r      <= hit_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: tb/sv/btm_verdict_checker.sv
// ----------------------------------------------------------------------------
// btm_verdict_checker
// Watches the word, result and register ports of the bloom token membership
// test, keeps its own copy of the filter, the three running hashes per token
// and per query, and the register settings, and checks every verdict word
// field by field against the oldest predicted verdict.
// ----------------------------------------------------------------------------
module btm_verdict_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  btm_pkg::in_item_t  in_item,
  input  logic               out_empty,
  input  logic               out_pop,
  input  btm_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  output int                 pending_verdicts,
  output int                 fail_count,
  output int                 checked_verdicts
);

  localparam int          FILTER_BYTES = 1024;
  localparam logic [31:0] FNV_PRIME    = 32'd16777619;

  // Filter copy and query tracking state
  logic [7:0]         filter_mem [FILTER_BYTES];
  logic [31:0]        tok_djb, tok_fnv, tok_sdbm;
  logic [31:0]        qry_djb, qry_fnv, qry_sdbm;
  bit                 in_tok, any_tok, all_hit;
  bit                 mode_tok;
  logic [3:0]         idx_bits;
  btm_pkg::out_item_t verdict_q [$];
  int                 errors  = 0;
  int                 checked = 0;

  function automatic logic [31:0] djb_next(input logic [31:0] h, input logic [7:0] c);
    return h * 32'd33 + {24'd0, c};
  endfunction

  function automatic logic [31:0] fnv_next(input logic [31:0] h, input logic [7:0] c);
    return (h ^ {24'd0, c}) * FNV_PRIME;
  endfunction

  // 2^6 + 2^16 - 1 folded into one multiplier
  function automatic logic [31:0] sdbm_next(input logic [31:0] h, input logic [7:0] c);
    return h * 32'd65599 + {24'd0, c};
  endfunction

  // Space, quote, colon, LF, CR, tab, comma, braces and brackets split tokens
  function automatic bit splits_token(input logic [7:0] c);
    case (c)
      8'h20, 8'h22, 8'h3A, 8'h0A, 8'h0D, 8'h09,
      8'h2C, 8'h7B, 8'h7D, 8'h5B, 8'h5D: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Mask to index_bits, then wrap into the 8192-bit filter
  function automatic bit filter_hit(input logic [31:0] h);
    logic [31:0] mask;
    logic [31:0] pos;
    mask = (32'd1 << idx_bits) - 32'd1;
    pos  = h & mask;
    return filter_mem[pos[12:3]][pos[2:0]];
  endfunction

  function automatic bit triple_hit(input logic [31:0] a, input logic [31:0] b,
                                    input logic [31:0] c);
    return filter_hit(a) && filter_hit(b) && filter_hit(c);
  endfunction

  task automatic restart_token();
    tok_djb  = btm_pkg::DJB_INIT;
    tok_fnv  = btm_pkg::FNV_INIT;
    tok_sdbm = btm_pkg::SDBM_INIT;
    in_tok   = 1'b0;
  endtask

  task automatic restart_query();
    restart_token();
    qry_djb  = btm_pkg::DJB_INIT;
    qry_fnv  = btm_pkg::FNV_INIT;
    qry_sdbm = btm_pkg::SDBM_INIT;
    any_tok  = 1'b0;
    all_hit  = 1'b1;
  endtask

  task automatic close_token();
    if (!triple_hit(tok_djb, tok_fnv, tok_sdbm)) all_hit = 1'b0;
    any_tok = 1'b1;
    restart_token();
  endtask

  // Fold one accepted input word into the state; queue a verdict on last
  task automatic absorb_word(input btm_pkg::in_item_t w);
    logic [7:0]         c;
    btm_pkg::out_item_t v;
    if (w.action == btm_pkg::ACT_LOAD) begin
      if (w.load_address < FILTER_BYTES) filter_mem[w.load_address] = w.load_data;
    end else begin
      c = w.query_byte;
      qry_djb  = djb_next(qry_djb, c);
      qry_fnv  = fnv_next(qry_fnv, c);
      qry_sdbm = sdbm_next(qry_sdbm, c);
      if (splits_token(c)) begin
        if (in_tok) close_token();
      end else begin
        tok_djb  = djb_next(tok_djb, c);
        tok_fnv  = fnv_next(tok_fnv, c);
        tok_sdbm = sdbm_next(tok_sdbm, c);
        in_tok   = 1'b1;
      end
      if (w.last) begin
        if (in_tok) close_token();
        if (mode_tok && any_tok) begin
          v.possibly_present = all_hit;
          v.whole_query_used = 1'b0;
        end else begin
          v.possibly_present = triple_hit(qry_djb, qry_fnv, qry_sdbm);
          v.whole_query_used = 1'b1;
        end
        verdict_q.push_back(v);
        restart_query();
      end
    end
  endtask

  // Compare one popped verdict word with the oldest prediction
  task automatic check_verdict(input btm_pkg::out_item_t got);
    btm_pkg::out_item_t want;
    if (verdict_q.size() == 0) begin
      $error("verdict word %b arrived with none predicted", got);
      errors++;
    end else begin
      want = verdict_q.pop_front();
      checked++;
      if (got.possibly_present !== want.possibly_present) begin
        $error("possibly_present: expected %0b, got %0b",
               want.possibly_present, got.possibly_present);
        errors++;
      end
      if (got.whole_query_used !== want.whole_query_used) begin
        $error("whole_query_used: expected %0b, got %0b",
               want.whole_query_used, got.whole_query_used);
        errors++;
      end
    end
  endtask

  // Sample all ports on the rising edge; pops are checked before new words
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FILTER_BYTES; i++) filter_mem[i] = 8'd0;
      mode_tok = 1'b1;
      idx_bits = 4'd13;
      restart_query();
      verdict_q.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        if (cfg_index == btm_pkg::CFG_TOKENIZE) mode_tok = cfg_data[0];
        else if (cfg_index == btm_pkg::CFG_INDEX_BITS) idx_bits = cfg_data;
      end
      if (out_pop && out_empty === 1'b0) check_verdict(out_item);
      if (in_push && in_full === 1'b0) absorb_word(in_item);
    end
    pending_verdicts <= verdict_q.size();
    fail_count       <= errors;
    checked_verdicts <= checked;
  end

endmodule

// File: tb/sv/bloom_token_membership_test_tb.sv
// ----------------------------------------------------------------------------
// bloom_token_membership_test_tb
// Stimulus and verdict for the bloom token membership test. Fills the whole
// filter, runs a short directed set, then random queries under a series of
// register settings with random idling on both sides, one long result
// hold-off and drained pauses between settings. Checking is left to
// btm_verdict_checker.
// ----------------------------------------------------------------------------
module bloom_token_membership_test_tb;

  localparam int FILTER_BYTES = 1024;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_WORDS  = 90;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int N_SETTINGS   = 8;
  localparam int IN_W         = $bits(btm_pkg::in_item_t);

  // Register settings per phase: reset values, both modes, range ends and beyond
  localparam bit         PHASE_TOK [N_SETTINGS] = '{1'b1, 1'b0, 1'b1, 1'b0,
                                                    1'b1, 1'b1, 1'b0, 1'b0};
  localparam logic [3:0] PHASE_IDX [N_SETTINGS] = '{4'd13, 4'd13, 4'd6, 4'd6,
                                                    4'd15, 4'd0, 4'd10, 4'd14};

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_push   = 1'b0;
  logic               in_full;
  btm_pkg::in_item_t  in_item   = '0;
  logic               out_empty;
  logic               out_pop   = 1'b0;
  btm_pkg::out_item_t out_item;
  logic               cfg_we    = 1'b0;
  logic [0:0]         cfg_index = btm_pkg::CFG_TOKENIZE;
  logic [3:0]         cfg_data  = 4'd0;

  int pending_verdicts;
  int fail_count;
  int checked_verdicts;
  int cycle_count = 0;
  int load_words  = 0;
  int query_words = 0;
  bit idle_on     = 1'b0;
  bit hold_req    = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bloom_token_membership_test u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  btm_verdict_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_item          (in_item),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_item         (out_item),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pending_verdicts (pending_verdicts),
    .fail_count       (fail_count),
    .checked_verdicts (checked_verdicts)
  );

  // Mostly no gap, some short, a few long
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Filter bytes lean towards set bits so that verdicts go both ways
  function automatic logic [7:0] dense_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 8'h00;
    if (r < 8) return 8'hFF;
    if (r < 20) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 255) | $urandom_range(0, 255) | $urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] delim_at(input int k);
    case (k)
      0: return 8'h20;        // space
      1: return 8'h22;        // double quote
      2: return 8'h3A;        // colon
      3: return 8'h0A;        // LF
      4: return 8'h0D;        // CR
      5: return 8'h09;        // tab
      6: return 8'h2C;        // comma
      7: return 8'h7B;        // open brace
      8: return 8'h7D;        // close brace
      9: return 8'h5B;        // open bracket
      default: return 8'h5D;  // close bracket
    endcase
  endfunction

  // Letters and digits mostly; any byte now and then, which may split the token
  function automatic logic [7:0] token_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 80) return 8'h30 + 8'($urandom_range(0, 9));
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one word, idling first if the phase allows it, and hold until taken
  task automatic send_word(input btm_pkg::in_item_t w);
    int gap;
    gap = idle_on ? rand_gap() : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      in_item <= IN_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (in_full !== 1'b0);
    if (w.action == btm_pkg::ACT_LOAD) load_words++;
    else query_words++;
  endtask

  // Unused fields carry random bits
  task automatic send_load(input logic [9:0] addr, input logic [7:0] data);
    btm_pkg::in_item_t w;
    w = IN_W'($urandom);
    w.action       = btm_pkg::ACT_LOAD;
    w.load_address = addr;
    w.load_data    = data;
    send_word(w);
  endtask

  task automatic send_byte(input logic [7:0] c, input logic fin);
    btm_pkg::in_item_t w;
    w = IN_W'($urandom);
    w.action     = btm_pkg::ACT_QUERY;
    w.query_byte = c;
    w.last       = fin;
    send_word(w);
  endtask

  // Build a tokenised query, sometimes delimiters only; drop in stray loads
  task automatic random_query(input bit finish);
    logic [7:0] q [$];
    int         ntok;
    int         len;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 4)) q.push_back(delim_at($urandom_range(0, 10)));
    end else begin
      if ($urandom_range(0, 3) == 0) q.push_back(delim_at($urandom_range(0, 10)));
      ntok = $urandom_range(1, 3);
      for (int t = 0; t < ntok; t++) begin
        if (t > 0) repeat ($urandom_range(1, 2)) q.push_back(delim_at($urandom_range(0, 10)));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        repeat (len) q.push_back(token_char());
      end
      if ($urandom_range(0, 3) == 0) q.push_back(delim_at($urandom_range(0, 10)));
    end
    foreach (q[i]) begin
      if ($urandom_range(0, 19) == 0) send_load(10'($urandom_range(0, 1023)), dense_byte());
      send_byte(q[i], finish && (i == q.size() - 1));
    end
  endtask

  task automatic write_cfg(input bit tok, input logic [3:0] ib);
    cfg_we    <= 1'b1;
    cfg_index <= btm_pkg::CFG_TOKENIZE;
    cfg_data  <= {3'd0, tok};
    @(posedge clk);
    cfg_index <= btm_pkg::CFG_INDEX_BITS;
    cfg_data  <= ib;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stop offering, wait for every verdict, then let the back end settle
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_verdicts != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random pop pattern, one long hold-off on request
  initial begin
    int span;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!idle_on) begin
        out_pop <= 1'b1;
        @(posedge clk);
      end else begin
        span = rand_gap() + 1;
        out_pop <= ($urandom_range(0, 3) != 0);
        repeat (span) @(posedge clk);
      end
    end
  end

  // Input side
  initial begin
    int mark;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    write_cfg(PHASE_TOK[0], PHASE_IDX[0]);

    // Fill the whole filter so that every index reads a written byte
    idle_on = 1'b0;
    for (int a = 0; a < FILTER_BYTES; a++) send_load(a[9:0], dense_byte());
    idle_on = 1'b1;

    // Address and data extremes
    send_load(10'd1023, 8'h00);
    send_load(10'd0, 8'hFF);
    // Single-byte queries at the byte extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Two tokens split by a space: "a b"
    send_byte(8'h61, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h62, 1'b1);
    // Delimiters only, every one of them: the whole query gets hashed
    for (int k = 0; k < 11; k++) send_byte(delim_at(k), k == 10);
    // Filter write in the middle of a query
    send_byte(8'h71, 1'b0);
    send_load(10'd5, dense_byte());
    send_byte(8'h72, 1'b1);
    // Leave "zz" open; the first random query of the opening phase carries it on
    send_byte(8'h7A, 1'b0);
    send_byte(8'h7A, 1'b0);

    for (int p = 0; p < N_SETTINGS; p++) begin
      if (p > 0) begin
        wait_drained();
        write_cfg(PHASE_TOK[p], PHASE_IDX[p]);
      end
      idle_on = (p % 3) != 2;
      mark = load_words + query_words;
      // Back up the result side while short queries keep coming
      if (p == 2) begin
        hold_req = 1'b1;
        repeat (60) send_byte(token_char(), 1'b1);
      end
      while (load_words + query_words - mark < PHASE_WORDS) random_query(1'b1);
      // Sometimes carry an unfinished query across the register change
      if ($urandom_range(0, 1) == 1) random_query(1'b0);
    end

    wait_drained();
    $display("Run covered %0d filter words and %0d query bytes over %0d register settings",
             load_words, query_words, N_SETTINGS);
    $display("%0d verdicts compared, %0d mismatches", checked_verdicts, fail_count);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
design/btm_pkg.sv
design/btm_ram.sv
design/btm_queue.sv
design/btm_front.sv
design/btm_back.sv
design/bloom_token_membership_test.sv
tb/sv/btm_verdict_checker.sv
tb/sv/bloom_token_membership_test_tb.sv
